// ===== rtl/mpva_pkg.sv =====
// Shared constants, types and codes of the polyphonic voice allocator.
package mpva_pkg;

    localparam int VOICES     = 16;
    localparam int HELD_DEPTH = 128;
    localparam int KEYS       = 128;

    localparam int VI_W  = $clog2(VOICES);
    localparam int PTR_W = $clog2(VOICES + 1);
    localparam int HA_W  = $clog2(HELD_DEPTH);
    localparam int CNT_W = $clog2(HELD_DEPTH + 1);
    localparam int KEY_W = 7;

    localparam logic [3:0]       REQ_NOTE_OFF   = 4'h8;
    localparam logic [3:0]       REQ_NOTE_ON    = 4'h9;
    localparam logic [3:0]       REQ_AFTERTOUCH = 4'hA;
    localparam logic [3:0]       REQ_CONTROL    = 4'hB;
    localparam logic [KEY_W-1:0] CC_SUSTAIN     = 7'h40;
    localparam logic [KEY_W-1:0] PEDAL_THRESH   = 7'd64;
    localparam logic [KEY_W-1:0] NOTE_RESET     = 7'd60;
    localparam logic [PTR_W-1:0] PTR_NONE       = PTR_W'(VOICES);

    localparam logic [2:0] MODE_REG_RESET = 3'd2;
    localparam logic [2:0] MODE_REG_MAX   = 3'd4;

    typedef enum logic [2:0] {
        MODE_ROTATE   = 3'd0,
        MODE_REUSE    = 3'd1,
        MODE_RESET    = 3'd2,
        MODE_REASSIGN = 3'd3,
        MODE_UNISON   = 3'd4
    } mode_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_PRESS, OP_PEDAL_ON,
        OP_RM_RD, OP_RM_CMP, OP_SH_RD, OP_SH_WR, OP_SH_END,
        OP_SP_RD, OP_SPK_WR, OP_SPF_WR, OP_UNI_RD, OP_UNI_WR,
        OP_RV_CHK, OP_RV_POP, OP_PR_START, OP_PR_CHK, OP_PR_POP,
        OP_OUT_RD, OP_OUT_LD
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PRESS, ST_PEDAL_ON,
        ST_RM_RD, ST_RM_CMP, ST_SH_RD, ST_SH_WR, ST_SH_END, ST_REL,
        ST_SPK_RD, ST_SPK_WR, ST_SPF_RD, ST_SPF_WR, ST_UNI_RD, ST_UNI_WR,
        ST_RV_CHK, ST_RV_POP, ST_PR_START, ST_PR_CHK, ST_PR_POP,
        ST_OUT_RD, ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic scan_more;
        logic match;
        logic shift_more;
        logic count_zero;
        logic voice_last;
        logic pop_cond;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/mpva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mpva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mpva_dp.sv =====
// Datapath: voice registers, held-note list, key tables and result register.
module mpva_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpva_pkg::op_t                  cmd,
    input  mpva_pkg::mode_t                mode,
    input  logic [3:0]                     req_type,
    input  logic [6:0]                     key_number,
    input  logic [6:0]                     data_value,
    input  logic                           out_ready,
    output mpva_pkg::status_t              status,
    output logic                           out_valid,
    output logic [3:0]                     voice_index,
    output logic [6:0]                     pitch,
    output logic                           gate_on,
    output logic [6:0]                     velocity,
    output logic [6:0]                     aftertouch,
    output logic                           cache_full,
    output logic                           last_item
);
    import mpva_pkg::*;

    logic [KEY_W-1:0] note_reg [VOICES];
    logic [KEY_W-1:0] note_next [VOICES];
    logic [VOICES-1:0] gate_reg, gate_next, sus_reg, sus_next;
    logic pedal_reg, pedal_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [VI_W-1:0] steal_reg, steal_next;
    logic [CNT_W-1:0] count_reg, count_next, idx_reg, idx_next;
    logic [VI_W-1:0] vi_reg, vi_next;
    logic drop_reg, drop_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEYS-1:0] vel_vld_reg, vel_vld_next, at_vld_reg, at_vld_next;
    logic vel_hit_reg, at_hit_reg;
    logic out_valid_reg;
    logic [VI_W-1:0] o_vi_reg;
    logic [KEY_W-1:0] o_pitch_reg, o_vel_reg, o_at_reg;
    logic o_gate_reg, o_drop_reg, o_last_reg;

    logic h_we, h_re;
    logic [HA_W-1:0] h_waddr, h_raddr;
    logic [KEY_W-1:0] h_wdata, h_rd, vel_rd, at_rd;
    logic t_vel_we, t_at_we, t_re;

    logic [VOICES-1:0] busy;
    logic [PTR_W-1:0] first_v;
    logic [PTR_W:0] cand;
    logic free_found, reuse_found;
    logic [VI_W-1:0] free_v, reuse_v, steal_inc, vi_adv, v_sel;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W:0] idx_inc;
    logic mode_low, voice_hit, out_free;
    logic push_req;
    logic [KEY_W-1:0] push_val, cur_note;

    assign busy      = gate_reg | sus_reg;
    assign mode_low  = (mode == MODE_ROTATE) || (mode == MODE_REUSE) || (mode == MODE_RESET);
    assign steal_inc = (steal_reg == VI_W'(VOICES - 1)) ? '0 : steal_reg + 1'b1;
    assign vi_adv    = (vi_reg == VI_W'(VOICES - 1)) ? '0 : vi_reg + 1'b1;
    assign cnt_dec   = count_reg - 1'b1;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign cur_note  = note_reg[vi_reg];
    assign voice_hit = (cur_note == key_reg);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        logic [PTR_W-1:0] start;
        start = ((mode == MODE_ROTATE) || (mode == MODE_REUSE)) ? ptr_reg : PTR_NONE;
        first_v = (start >= PTR_W'(VOICES - 1)) ? '0 : start + 1'b1;
        free_found = 1'b0;
        free_v = '0;
        cand = '0;
        for (int k = VOICES - 1; k >= 0; k--)
        begin
            cand = {1'b0, first_v} + (PTR_W + 1)'(k);
            if (cand >= (PTR_W + 1)'(VOICES))
            begin
                cand = cand - (PTR_W + 1)'(VOICES);
            end
            if (!busy[cand[VI_W-1:0]])
            begin
                free_found = 1'b1;
                free_v = cand[VI_W-1:0];
            end
        end
        reuse_found = 1'b0;
        reuse_v = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (note_reg[i] == key_reg)
            begin
                reuse_found = 1'b1;
                reuse_v = VI_W'(i);
            end
        end
    end

    always_comb
    begin
        note_next    = note_reg;
        gate_next    = gate_reg;
        sus_next     = sus_reg;
        pedal_next   = pedal_reg;
        ptr_next     = ptr_reg;
        steal_next   = steal_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        vi_next      = vi_reg;
        drop_next    = drop_reg;
        vel_vld_next = vel_vld_reg;
        at_vld_next  = at_vld_reg;
        h_we = 1'b0;
        h_re = 1'b0;
        h_waddr = count_reg[HA_W-1:0];
        h_raddr = cnt_dec[HA_W-1:0];
        h_wdata = key_reg;
        t_vel_we = 1'b0;
        t_at_we = 1'b0;
        t_re = 1'b0;
        push_req = 1'b0;
        push_val = key_reg;
        v_sel = '0;
        unique case (cmd)
            OP_ACCEPT:
            begin
                drop_next = 1'b0;
                idx_next = '0;
                vi_next = '0;
                if (req_type == REQ_NOTE_ON && data_value != '0)
                begin
                    t_vel_we = 1'b1;
                    vel_vld_next[key_number] = 1'b1;
                end
                if (req_type == REQ_AFTERTOUCH)
                begin
                    t_at_we = 1'b1;
                    at_vld_next[key_number] = 1'b1;
                end
            end
            OP_PRESS:
            begin
                if (mode == MODE_UNISON)
                begin
                    push_req = 1'b1;
                    for (int i = 0; i < VOICES; i++)
                    begin
                        note_next[i] = key_reg;
                    end
                    gate_next = '1;
                    sus_next = {VOICES{pedal_reg}};
                end
                else
                begin
                    if (mode == MODE_REUSE && reuse_found)
                    begin
                        v_sel = reuse_v;
                    end
                    else if (free_found)
                    begin
                        v_sel = free_v;
                        steal_next = free_v;
                    end
                    else
                    begin
                        v_sel = steal_inc;
                        steal_next = steal_inc;
                        if (mode_low && gate_reg[steal_inc])
                        begin
                            push_req = 1'b1;
                            push_val = note_reg[steal_inc];
                        end
                    end
                    if (mode == MODE_REASSIGN)
                    begin
                        push_req = 1'b1;
                    end
                    ptr_next = PTR_W'(v_sel);
                    note_next[v_sel] = key_reg;
                    gate_next[v_sel] = 1'b1;
                    sus_next[v_sel] = pedal_reg;
                end
                if (push_req)
                begin
                    if (count_reg >= CNT_W'(HELD_DEPTH))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        h_we = 1'b1;
                        h_wdata = push_val;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            OP_PEDAL_ON:
            begin
                pedal_next = 1'b1;
                sus_next = gate_reg;
            end
            OP_RM_RD:
            begin
                h_re = 1'b1;
                h_raddr = idx_reg[HA_W-1:0];
            end
            OP_RM_CMP:
            begin
                if (h_rd != key_reg)
                begin
                    idx_next = idx_inc[CNT_W-1:0];
                end
            end
            OP_SH_RD:
            begin
                h_re = 1'b1;
                h_raddr = idx_inc[HA_W-1:0];
            end
            OP_SH_WR:
            begin
                h_we = 1'b1;
                h_waddr = idx_reg[HA_W-1:0];
                h_wdata = h_rd;
                idx_next = idx_inc[CNT_W-1:0];
            end
            OP_SH_END:
            begin
                count_next = cnt_dec;
            end
            OP_SP_RD:
            begin
                h_re = 1'b1;
                h_raddr = HA_W'(vi_reg);
            end
            OP_SPK_WR:
            begin
                if (CNT_W'(vi_reg) < count_reg)
                begin
                    if (!sus_reg[vi_reg])
                    begin
                        note_next[vi_reg] = h_rd;
                    end
                    sus_next[vi_reg] = pedal_reg;
                end
                else
                begin
                    gate_next[vi_reg] = 1'b0;
                end
                vi_next = vi_adv;
            end
            OP_SPF_WR:
            begin
                if (CNT_W'(vi_reg) < count_reg)
                begin
                    note_next[vi_reg] = h_rd;
                    gate_next[vi_reg] = 1'b1;
                end
                else
                begin
                    gate_next[vi_reg] = 1'b0;
                end
                vi_next = vi_adv;
            end
            OP_UNI_RD:
            begin
                h_re = 1'b1;
            end
            OP_UNI_WR:
            begin
                for (int i = 0; i < VOICES; i++)
                begin
                    if (count_reg != '0)
                    begin
                        note_next[i] = h_rd;
                    end
                end
                gate_next = {VOICES{count_reg != '0}};
            end
            OP_RV_CHK:
            begin
                if (voice_hit && !sus_reg[vi_reg] && count_reg != '0)
                begin
                    h_re = 1'b1;
                    count_next = cnt_dec;
                end
                else
                begin
                    if (voice_hit)
                    begin
                        gate_next[vi_reg] = 1'b0;
                    end
                    vi_next = vi_adv;
                end
            end
            OP_RV_POP:
            begin
                note_next[vi_reg] = h_rd;
                vi_next = vi_adv;
            end
            OP_PR_START:
            begin
                pedal_next = 1'b0;
                sus_next = '0;
            end
            OP_PR_CHK:
            begin
                if (count_reg != '0)
                begin
                    h_re = 1'b1;
                    count_next = cnt_dec;
                end
                else
                begin
                    vi_next = vi_adv;
                end
            end
            OP_PR_POP:
            begin
                note_next[vi_reg] = h_rd;
                gate_next[vi_reg] = 1'b1;
                vi_next = vi_adv;
            end
            OP_OUT_RD:
            begin
                t_re = 1'b1;
            end
            OP_OUT_LD:
            begin
                if (out_free)
                begin
                    vi_next = vi_adv;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                note_reg[i] <= NOTE_RESET;
            end
            gate_reg      <= '0;
            sus_reg       <= '0;
            pedal_reg     <= 1'b0;
            ptr_reg       <= PTR_NONE;
            steal_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            vi_reg        <= '0;
            drop_reg      <= 1'b0;
            vel_vld_reg   <= '0;
            at_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            note_reg    <= note_next;
            gate_reg    <= gate_next;
            sus_reg     <= sus_next;
            pedal_reg   <= pedal_next;
            ptr_reg     <= ptr_next;
            steal_reg   <= steal_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            vi_reg      <= vi_next;
            drop_reg    <= drop_next;
            vel_vld_reg <= vel_vld_next;
            at_vld_reg  <= at_vld_next;
            if (cmd == OP_OUT_LD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == OP_ACCEPT)
        begin
            key_reg <= key_number;
        end
        if (t_re)
        begin
            vel_hit_reg <= vel_vld_reg[cur_note];
            at_hit_reg  <= at_vld_reg[cur_note];
        end
        if (cmd == OP_OUT_LD && out_free)
        begin
            o_vi_reg    <= vi_reg;
            o_pitch_reg <= cur_note;
            o_gate_reg  <= gate_reg[vi_reg] | sus_reg[vi_reg];
            o_vel_reg   <= vel_hit_reg ? vel_rd : '0;
            o_at_reg    <= at_hit_reg ? at_rd : '0;
            o_drop_reg  <= drop_reg;
            o_last_reg  <= (vi_reg == VI_W'(VOICES - 1));
        end
    end

    mpva_ram #(.WIDTH(KEY_W), .DEPTH(HELD_DEPTH)) u_held (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rd)
    );

    mpva_ram #(.WIDTH(KEY_W), .DEPTH(KEYS)) u_vel (
        .clk   (clk),
        .we    (t_vel_we),
        .waddr (key_number),
        .wdata (data_value),
        .re    (t_re),
        .raddr (cur_note),
        .rdata (vel_rd)
    );

    mpva_ram #(.WIDTH(KEY_W), .DEPTH(KEYS)) u_at (
        .clk   (clk),
        .we    (t_at_we),
        .waddr (key_number),
        .wdata (data_value),
        .re    (t_re),
        .raddr (cur_note),
        .rdata (at_rd)
    );

    assign status.scan_more  = idx_reg < count_reg;
    assign status.match      = (h_rd == key_reg);
    assign status.shift_more = idx_inc < {1'b0, count_reg};
    assign status.count_zero = (count_reg == '0);
    assign status.voice_last = (vi_reg == VI_W'(VOICES - 1));
    assign status.pop_cond   = voice_hit && !sus_reg[vi_reg] && (count_reg != '0);
    assign status.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign voice_index = 4'(o_vi_reg);
    assign pitch       = o_pitch_reg;
    assign gate_on     = o_gate_reg;
    assign velocity    = o_vel_reg;
    assign aftertouch  = o_at_reg;
    assign cache_full  = o_drop_reg;
    assign last_item   = o_last_reg;

endmodule

// ===== rtl/mpva_ctrl.sv =====
// Controller: sequences each message through the datapath operations.
module mpva_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  mpva_pkg::mode_t     mode,
    input  logic                in_valid,
    input  logic [3:0]          req_type,
    input  logic [6:0]          key_number,
    input  logic [6:0]          data_value,
    input  mpva_pkg::status_t   status,
    output logic                in_ready,
    output mpva_pkg::op_t       cmd
);
    import mpva_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (req_type == REQ_NOTE_OFF)
                    begin
                        state_next = ST_RM_RD;
                    end
                    else if (req_type == REQ_NOTE_ON)
                    begin
                        state_next = (data_value != '0) ? ST_PRESS : ST_RM_RD;
                    end
                    else if (req_type == REQ_CONTROL && key_number == CC_SUSTAIN)
                    begin
                        state_next = (data_value >= PEDAL_THRESH) ? ST_PEDAL_ON : ST_PR_START;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_PRESS, ST_PEDAL_ON, ST_UNI_WR:
            begin
                state_next = ST_OUT_RD;
            end
            ST_RM_RD:
            begin
                state_next = status.scan_more ? ST_RM_CMP : ST_REL;
            end
            ST_RM_CMP:
            begin
                state_next = status.match ? ST_SH_RD : ST_RM_RD;
            end
            ST_SH_RD:
            begin
                state_next = status.shift_more ? ST_SH_WR : ST_SH_END;
            end
            ST_SH_WR:
            begin
                state_next = ST_SH_RD;
            end
            ST_SH_END:
            begin
                state_next = ST_REL;
            end
            ST_REL:
            begin
                priority if (mode == MODE_REASSIGN)
                begin
                    state_next = ST_SPK_RD;
                end
                else if (mode == MODE_UNISON)
                begin
                    state_next = ST_UNI_RD;
                end
                else
                begin
                    state_next = ST_RV_CHK;
                end
            end
            ST_SPK_RD:
            begin
                state_next = ST_SPK_WR;
            end
            ST_SPK_WR:
            begin
                state_next = status.voice_last ? ST_OUT_RD : ST_SPK_RD;
            end
            ST_SPF_RD:
            begin
                state_next = ST_SPF_WR;
            end
            ST_SPF_WR:
            begin
                state_next = status.voice_last ? ST_OUT_RD : ST_SPF_RD;
            end
            ST_UNI_RD:
            begin
                state_next = ST_UNI_WR;
            end
            ST_RV_CHK:
            begin
                priority if (status.pop_cond)
                begin
                    state_next = ST_RV_POP;
                end
                else if (status.voice_last)
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_RV_POP:
            begin
                state_next = status.voice_last ? ST_OUT_RD : ST_RV_CHK;
            end
            ST_PR_START:
            begin
                priority if (mode == MODE_REASSIGN)
                begin
                    state_next = ST_SPF_RD;
                end
                else if (mode == MODE_UNISON)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_PR_CHK;
                end
            end
            ST_PR_CHK:
            begin
                priority if (!status.count_zero)
                begin
                    state_next = ST_PR_POP;
                end
                else if (status.voice_last)
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_PR_POP:
            begin
                state_next = status.voice_last ? ST_OUT_RD : ST_PR_CHK;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.voice_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd = in_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_PRESS:    cmd = OP_PRESS;
            ST_PEDAL_ON: cmd = OP_PEDAL_ON;
            ST_RM_RD:    cmd = OP_RM_RD;
            ST_RM_CMP:   cmd = OP_RM_CMP;
            ST_SH_RD:    cmd = OP_SH_RD;
            ST_SH_WR:    cmd = OP_SH_WR;
            ST_SH_END:   cmd = OP_SH_END;
            ST_REL:      cmd = OP_NONE;
            ST_SPK_RD:   cmd = OP_SP_RD;
            ST_SPK_WR:   cmd = OP_SPK_WR;
            ST_SPF_RD:   cmd = OP_SP_RD;
            ST_SPF_WR:   cmd = OP_SPF_WR;
            ST_UNI_RD:   cmd = OP_UNI_RD;
            ST_UNI_WR:   cmd = OP_UNI_WR;
            ST_RV_CHK:   cmd = OP_RV_CHK;
            ST_RV_POP:   cmd = OP_RV_POP;
            ST_PR_START: cmd = OP_PR_START;
            ST_PR_CHK:   cmd = OP_PR_CHK;
            ST_PR_POP:   cmd = OP_PR_POP;
            ST_OUT_RD:   cmd = OP_OUT_RD;
            ST_OUT_LD:   cmd = OP_OUT_LD;
            default:     cmd = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/midi_poly_voice_allocator.sv =====
// Top level of the polyphonic voice allocator: register port, controller and datapath.
//
// One MIDI channel message is taken per transfer on the input channel, and
// sixteen voice results follow on the output channel, voice 0 first, the last
// one marked by last_item. Each message takes an acceptance step, its own
// processing, then a table read and an output load per voice result, each
// load waiting until the output is free. Aftertouch, other controllers, pedal
// down and note-on need no loop before the results; a note-off first searches
// the held list and shifts the later entries down over any match, then updates
// the voices; pedal up also updates the voices. All loops run through one port
// pair of the held-note RAM. A new message is taken as soon as the final
// result sits in the output register. The per-key tables read as zero until
// written; no clearing pass is needed after reset. poly_mode is at address 0,
// reset value 2; values 5 to 7 behave as 2.
module midi_poly_voice_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [6:0]  key_number,
    input  logic [6:0]  data_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  voice_index,
    output logic [6:0]  pitch,
    output logic        gate_on,
    output logic [6:0]  velocity,
    output logic [6:0]  aftertouch,
    output logic        cache_full,
    output logic        last_item
);
    import mpva_pkg::*;

    logic [2:0] mode_reg;
    mode_t      mode;
    op_t        cmd;
    status_t    status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_REG_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            mode_reg <= pwdata[2:0];
        end
    end

    assign mode   = (mode_reg > MODE_REG_MAX) ? MODE_RESET : mode_t'(mode_reg);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, mode_reg};

    mpva_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .key_number (key_number),
        .data_value (data_value),
        .status     (status),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    mpva_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .req_type    (req_type),
        .key_number  (key_number),
        .data_value  (data_value),
        .out_ready   (out_ready),
        .status      (status),
        .out_valid   (out_valid),
        .voice_index (voice_index),
        .pitch       (pitch),
        .gate_on     (gate_on),
        .velocity    (velocity),
        .aftertouch  (aftertouch),
        .cache_full  (cache_full),
        .last_item   (last_item)
    );

endmodule
